/* design/pgvu_pkg.sv */
// ----------------------------------------------------------------------------
// pgvu_pkg
// Types, constants and per-stage step functions for the pair gravity unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pgvu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam logic [31:0] GRAV_RESET = 32'(64'd1 << FRAC_BITS);

    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 33;
    localparam int CDIV_STEPS = 33;
    // front 4 + divide 65 + product 1 + component divide 34 + output 1
    localparam int LAT        = 4 + DIV_STEPS + 1 + 1 + CDIV_STEPS + 1 + 1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_DIST = 2'd1,
        ST_ZERO_MASS = 2'd2,
        ST_SAT       = 2'd3
    } status_t;

    typedef struct packed {
        logic zd;
        logic zm;
        logic nx;
        logic px;
        logic ny;
        logic py;
    } flags_t;

    typedef struct packed {
        flags_t       f;
        logic [31:0]  ax;
        logic [31:0]  ay;
        logic [97:0]  den;
        logic [64:0]  q;
        logic [97:0]  r1;
        logic [97:0]  r2;
        logic [63:0]  n1;
        logic [63:0]  n2;
        logic [63:0]  a1;
        logic [63:0]  a2;
        logic         ov1;
        logic         ov2;
        logic [32:0]  sr;
        logic [67:0]  ssq;
    } dv_t;

    typedef struct packed {
        flags_t           f;
        logic [32:0]      d;
        logic [3:0][32:0] rem;
        logic [3:0][32:0] lo;
        logic [3:0][32:0] quo;
        logic [3:0]       ov;
    } cd_t;

    // one quotient bit of both accel divides and, in the first SQRT_STEPS steps, one root bit of the distance
    function automatic dv_t dv_step(input dv_t p, input int k);
        dv_t         n;
        logic [98:0] t1;
        logic [98:0] t2;
        logic [67:0] csq;
        int          b;
        n  = p;
        b  = SQRT_STEPS - k;
        t1 = {p.r1, p.n1[6'(DIV_STEPS - k)]};
        t2 = {p.r2, p.n2[6'(DIV_STEPS - k)]};
        if (t1 >= {1'b0, p.den}) begin
            n.r1 = 98'(t1 - {1'b0, p.den});
            n.a1[6'(DIV_STEPS - k)] = 1'b1;
        end else begin
            n.r1 = t1[97:0];
        end
        if (t2 >= {1'b0, p.den}) begin
            n.r2 = 98'(t2 - {1'b0, p.den});
            n.a2[6'(DIV_STEPS - k)] = 1'b1;
        end else begin
            n.r2 = t2[97:0];
        end
        if (k <= SQRT_STEPS) begin
            csq = p.ssq + (68'(p.sr) << (b + 1)) + (68'd1 << (2 * b));
            if ({3'b000, p.q} >= csq) begin
                n.sr  = p.sr | (33'd1 << b);
                n.ssq = csq;
            end
        end
        return n;
    endfunction

    // one quotient bit of the four component divides
    function automatic cd_t cd_step(input cd_t p, input int k);
        cd_t         n;
        logic [33:0] t;
        n = p;
        for (int i = 0; i < 4; i++) begin
            t = {p.rem[i], p.lo[i][6'(CDIV_STEPS - k)]};
            if (t >= {1'b0, p.d}) begin
                n.rem[i] = 33'(t - {1'b0, p.d});
                n.quo[i][6'(CDIV_STEPS - k)] = 1'b1;
            end else begin
                n.rem[i] = t[32:0];
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* design/pair_gravity_velocity_update_unit.sv */
// ----------------------------------------------------------------------------
// pair_gravity_velocity_update_unit
// Velocity increments of a particle pair under mutual gravity, fixed point.
// ----------------------------------------------------------------------------
// The pipe's depth is set mostly by the 64-stage restoring divide for the
// accelerations and the 33-stage component divide.
// Throughput: one beat per cycle; the whole pipe stalls only while the
// output beat is held. Reset clears all valid bits and sets grav_constant
// to 1.0; payload registers are not reset.
`default_nettype none

module pair_gravity_velocity_update_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,     // grav_constant
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // first_x, first_y, second_x, second_y, first_mass, second_mass
    input  wire logic [191:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // first_dvx, first_dvy, second_dvx, second_dvy
    output logic [127:0]      m_tdata,
    output logic [1:0]        m_tuser        // status
);
    import pgvu_pkg::*;

    logic              adv;
    logic [LAT-1:0]    vld_reg;
    logic [31:0]       grav_reg;

    // stage 1
    logic [32:0] dx, dy;
    logic [31:0] ax_c, ay_c;
    logic [32:0] s_c;
    flags_t      f_c;
    flags_t      f1_reg, f2_reg, f3_reg, f4_reg;
    logic [31:0] ax1_reg, ay1_reg, ax2_reg, ay2_reg, ax3_reg, ay3_reg, ax4_reg, ay4_reg;
    logic [32:0] s1_reg, s2_reg, s3_reg;
    logic [31:0] m1_1_reg, m2_1_reg, m1_2_reg, m2_2_reg, m1_3_reg, m2_3_reg;
    logic [63:0] gm1_reg;
    // stage 2
    logic [63:0] sqx_reg, sqy_reg, bp0_reg, bp1_reg;
    // stage 3
    logic [64:0] q3_reg, q4_reg;
    logic [95:0] base_reg;
    // stage 4
    logic [64:0] dl_reg;
    logic [65:0] dh_reg;
    logic [2:0][63:0] n1p_reg, n2p_reg;

    logic [127:0] num1, num2;
    logic [97:0]  den_c;
    dv_t dv_next [0:DIV_STEPS];
    dv_t dv_reg  [0:DIV_STEPS];

    flags_t      mf_reg;
    logic [32:0] md_reg;
    logic [3:0][63:0] pl_reg, ph_reg;
    logic [63:0] a1_c, a2_c;

    cd_t cd_next [0:CDIV_STEPS];
    cd_t cd_reg  [0:CDIV_STEPS];
    logic [95:0] cnum [4];

    logic [3:0]       neg, sat;
    logic [32:0]      limit [4];
    logic [31:0]      mag   [4];
    logic [3:0][31:0] res;
    flags_t           ff;
    status_t          st_c;
    logic [127:0]     out_data_reg;
    status_t          out_st_reg;

    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            grav_reg <= GRAV_RESET;
        end else begin
            if (adv) begin
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            end
            if (cfg_we) begin
                grav_reg <= cfg_wdata;
            end
        end
    end

    always_comb begin
        dx   = {s_tdata[95], s_tdata[95:64]} - {s_tdata[31], s_tdata[31:0]};
        dy   = {s_tdata[127], s_tdata[127:96]} - {s_tdata[63], s_tdata[63:32]};
        ax_c = dx[32] ? 32'(-dx) : dx[31:0];
        ay_c = dy[32] ? 32'(-dy) : dy[31:0];
        s_c  = {1'b0, s_tdata[159:128]} + {1'b0, s_tdata[191:160]};
        f_c.zd = (ax_c == '0) && (ay_c == '0);
        f_c.zm = (s_c == '0);
        f_c.nx = dx[32];
        f_c.px = !dx[32] && (dx != '0);
        f_c.ny = dy[32];
        f_c.py = !dy[32] && (dy != '0);
    end

    // divide entry
    always_comb begin
        den_c = {33'd0, dl_reg} + {dh_reg, 32'd0};
        num1  = {64'd0, n1p_reg[0]} + {32'd0, n1p_reg[1], 32'd0} + {n1p_reg[2], 64'd0};
        num2  = {64'd0, n2p_reg[0]} + {32'd0, n2p_reg[1], 32'd0} + {n2p_reg[2], 64'd0};
        dv_next[0].f   = f4_reg;
        dv_next[0].ax  = ax4_reg;
        dv_next[0].ay  = ay4_reg;
        dv_next[0].den = den_c;
        dv_next[0].q   = q4_reg;
        dv_next[0].ov1 = {34'd0, num1[127:64]} >= den_c;
        dv_next[0].ov2 = {34'd0, num2[127:64]} >= den_c;
        dv_next[0].r1  = {34'd0, num1[127:64]};
        dv_next[0].r2  = {34'd0, num2[127:64]};
        dv_next[0].n1  = num1[63:0];
        dv_next[0].n2  = num2[63:0];
        dv_next[0].a1  = '0;
        dv_next[0].a2  = '0;
        dv_next[0].sr  = '0;
        dv_next[0].ssq = '0;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            dv_next[k] = dv_step(dv_reg[k-1], k);
        end
    end

    assign a1_c = dv_reg[DIV_STEPS].ov1 ? '1 : dv_reg[DIV_STEPS].a1;
    assign a2_c = dv_reg[DIV_STEPS].ov2 ? '1 : dv_reg[DIV_STEPS].a2;

    // component divide entry
    always_comb begin
        cd_next[0].f = mf_reg;
        cd_next[0].d = md_reg;
        for (int i = 0; i < 4; i++) begin
            cnum[i]          = {32'd0, pl_reg[i]} + {ph_reg[i], 32'd0};
            cd_next[0].ov[i] = cnum[i][95:33] >= {30'd0, md_reg};
            cd_next[0].rem[i] = cnum[i][65:33];
            cd_next[0].lo[i]  = cnum[i][32:0];
            cd_next[0].quo[i] = '0;
        end
        for (int k = 1; k <= CDIV_STEPS; k++) begin
            cd_next[k] = cd_step(cd_reg[k-1], k);
        end
    end

    // saturate, sign and status
    always_comb begin
        ff     = cd_reg[CDIV_STEPS].f;
        neg[0] = ff.nx;
        neg[1] = ff.ny;
        neg[2] = ff.px;
        neg[3] = ff.py;
        for (int i = 0; i < 4; i++) begin
            limit[i] = neg[i] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
            sat[i]   = cd_reg[CDIV_STEPS].ov[i] || (cd_reg[CDIV_STEPS].quo[i] > limit[i]);
            mag[i]   = sat[i] ? limit[i][31:0] : cd_reg[CDIV_STEPS].quo[i][31:0];
            res[i]   = (ff.zd || ff.zm) ? 32'd0 : (neg[i] ? 32'(-mag[i]) : mag[i]);
        end
        if (ff.zd) begin
            st_c = ST_ZERO_DIST;
        end else if (ff.zm) begin
            st_c = ST_ZERO_MASS;
        end else if (sat != '0) begin
            st_c = ST_SAT;
        end else begin
            st_c = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_reg   <= f_c;
            ax1_reg  <= ax_c;
            ay1_reg  <= ay_c;
            s1_reg   <= s_c;
            m1_1_reg <= s_tdata[159:128];
            m2_1_reg <= s_tdata[191:160];
            gm1_reg  <= 64'(grav_reg) * 64'(s_tdata[159:128]);

            f2_reg   <= f1_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            s2_reg   <= s1_reg;
            m1_2_reg <= m1_1_reg;
            m2_2_reg <= m2_1_reg;
            sqx_reg  <= 64'(ax1_reg) * 64'(ax1_reg);
            sqy_reg  <= 64'(ay1_reg) * 64'(ay1_reg);
            bp0_reg  <= 64'(gm1_reg[31:0]) * 64'(m2_1_reg);
            bp1_reg  <= 64'(gm1_reg[63:32]) * 64'(m2_1_reg);

            f3_reg   <= f2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            s3_reg   <= s2_reg;
            m1_3_reg <= m1_2_reg;
            m2_3_reg <= m2_2_reg;
            q3_reg   <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            base_reg <= {32'd0, bp0_reg} + {bp1_reg, 32'd0};

            f4_reg   <= f3_reg;
            ax4_reg  <= ax3_reg;
            ay4_reg  <= ay3_reg;
            q4_reg   <= q3_reg;
            dl_reg   <= 65'(q3_reg[31:0]) * 65'(s3_reg);
            dh_reg   <= 66'(q3_reg[64:32]) * 66'(s3_reg);
            for (int j = 0; j < 3; j++) begin
                n1p_reg[j] <= 64'(base_reg[32*j +: 32]) * 64'(m2_3_reg);
                n2p_reg[j] <= 64'(base_reg[32*j +: 32]) * 64'(m1_3_reg);
            end

            for (int k = 0; k <= DIV_STEPS; k++) begin
                dv_reg[k] <= dv_next[k];
            end

            mf_reg    <= dv_reg[DIV_STEPS].f;
            md_reg    <= dv_reg[DIV_STEPS].sr;
            pl_reg[0] <= 64'(a1_c[31:0])  * 64'(dv_reg[DIV_STEPS].ax);
            ph_reg[0] <= 64'(a1_c[63:32]) * 64'(dv_reg[DIV_STEPS].ax);
            pl_reg[1] <= 64'(a1_c[31:0])  * 64'(dv_reg[DIV_STEPS].ay);
            ph_reg[1] <= 64'(a1_c[63:32]) * 64'(dv_reg[DIV_STEPS].ay);
            pl_reg[2] <= 64'(a2_c[31:0])  * 64'(dv_reg[DIV_STEPS].ax);
            ph_reg[2] <= 64'(a2_c[63:32]) * 64'(dv_reg[DIV_STEPS].ax);
            pl_reg[3] <= 64'(a2_c[31:0])  * 64'(dv_reg[DIV_STEPS].ay);
            ph_reg[3] <= 64'(a2_c[63:32]) * 64'(dv_reg[DIV_STEPS].ay);

            for (int k = 0; k <= CDIV_STEPS; k++) begin
                cd_reg[k] <= cd_next[k];
            end

            out_data_reg <= res;
            out_st_reg   <= st_c;
        end
    end

    // a beat taken at the input shows up in the first stage
    a_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted beat lost at entry");

    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_ZERO_DIST || m_tuser == ST_ZERO_MASS) |-> m_tdata == '0)
        else $error("nonzero increment on error status");

    a_opp_x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_OK |-> !(m_tdata[31] && m_tdata[95]))
        else $error("x increments point the same way");

    a_sat_lim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_SAT |->
            (m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000 ||
             m_tdata[63:32] == 32'h7FFF_FFFF || m_tdata[63:32] == 32'h8000_0000 ||
             m_tdata[95:64] == 32'h7FFF_FFFF || m_tdata[95:64] == 32'h8000_0000 ||
             m_tdata[127:96] == 32'h7FFF_FFFF || m_tdata[127:96] == 32'h8000_0000))
        else $error("saturated status without a clamped field");

endmodule

`default_nettype wire

/* verif/pair_gravity_velocity_update_unit_tb.sv */
// ----------------------------------------------------------------------------
// pair_gravity_velocity_update_unit_tb
// Drives particle pairs into the gravity unit with random idle bursts on both
// sides, predicts each beat's velocity increments and status with wide exact
// arithmetic, and checks every output beat in order. The gravitational
// constant is changed between phases while the pipe is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_gravity_velocity_update_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pgvu_pkg::*;

    typedef struct packed {
        logic [31:0] sdy;
        logic [31:0] sdx;
        logic [31:0] fdy;
        logic [31:0] fdx;
        status_t     st;
    } dv_beat_t;

    // ------------------------------------------------------------------
    class increment_board;
        logic [31:0] grav;
        dv_beat_t    pending[$];
        int          errors;

        function new();
            grav   = GRAV_RESET;
            errors = 0;
        endfunction

        function automatic logic [31:0] axis_inc(logic [63:0] acc, logic [31:0] mag,
                                                 bit neg, logic [32:0] d, ref bit sat);
            logic [127:0] m;
            logic [31:0]  lim;
            logic [31:0]  v;
            m   = ({64'd0, acc} * {96'd0, mag}) / {95'd0, d};
            lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            if (m > {96'd0, lim}) begin
                sat = 1;
                v   = lim;
            end else begin
                v = m[31:0];
            end
            return neg ? -v : v;
        endfunction

        function void note_pair(logic [191:0] pair);
            logic signed [32:0] dx;
            logic signed [32:0] dy;
            logic [32:0]  ax;
            logic [32:0]  ay;
            logic [32:0]  s;
            logic [32:0]  d;
            logic [65:0]  q;
            logic [255:0] den;
            logic [255:0] base;
            logic [255:0] t;
            logic [63:0]  a1;
            logic [63:0]  a2;
            logic [31:0]  m1;
            logic [31:0]  m2;
            dv_beat_t     r;
            bit           sat;
            dx  = $signed(pair[95:64]) - $signed(pair[31:0]);
            dy  = $signed(pair[127:96]) - $signed(pair[63:32]);
            m1  = pair[159:128];
            m2  = pair[191:160];
            ax  = dx < 0 ? -dx : dx;
            ay  = dy < 0 ? -dy : dy;
            s   = {1'b0, m1} + {1'b0, m2};
            r   = '0;
            sat = 0;
            if (ax == 0 && ay == 0) begin
                r.st = ST_ZERO_DIST;
            end else if (s == 0) begin
                r.st = ST_ZERO_MASS;
            end else begin
                q = {33'd0, ax} * {33'd0, ax} + {33'd0, ay} * {33'd0, ay};
                d = 0;
                for (int b = 33; b >= 0; b--) begin
                    if ({66'd0, d | (33'd1 << b)} * {66'd0, d | (33'd1 << b)}
                        <= {66'd0, q})
                        d = d | (33'd1 << b);
                end
                den  = {190'd0, q} * {223'd0, s};
                // g*m1 fits in 64 bits
                base = {192'd0, 64'({32'd0, grav} * {32'd0, m1})} * {224'd0, m2};
                t    = (base * {224'd0, m2}) / den;
                a1   = t[255:64] != 0 ? '1 : t[63:0];
                t    = (base * {224'd0, m1}) / den;
                a2   = t[255:64] != 0 ? '1 : t[63:0];
                r.fdx = axis_inc(a1, ax[31:0], dx < 0, d, sat);
                r.fdy = axis_inc(a1, ay[31:0], dy < 0, d, sat);
                r.sdx = axis_inc(a2, ax[31:0], dx > 0, d, sat);
                r.sdy = axis_inc(a2, ay[31:0], dy > 0, d, sat);
                r.st  = sat ? ST_SAT : ST_OK;
            end
            pending.push_back(r);
        endfunction

        function void check_beat(logic [127:0] data, logic [1:0] user);
            dv_beat_t e;
            dv_beat_t a;
            a = {data[127:96], data[95:64], data[63:32], data[31:0], status_t'(user)};
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat %h st %0d", data, user);
                return;
            end
            e = pending.pop_front();
            if (a !== e) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp %h %h %h %h st %0d / got %h %h %h %h st %0d",
                             e.fdx, e.fdy, e.sdx, e.sdy, e.st,
                             a.fdx, a.fdy, a.sdx, a.sdy, a.st);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_we = 0;
    logic [31:0]  cfg_wdata = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [191:0] s_tdata = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;

    increment_board board = new();
    bit             calm = 0;
    longint         cycles = 0;

    pair_gravity_velocity_update_unit uut (
        .aclk, .aresetn, .cfg_we, .cfg_wdata, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_beat(m_tdata, m_tuser);
    end

    // output stall bursts
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            m_tready <= 1;
            n = $urandom_range(1, 40);
            repeat (n) @(posedge aclk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 0;
                n = $urandom_range(1, 16);
                repeat (n) @(posedge aclk);
            end
        end
    end

    task automatic send_pair(logic [191:0] pair);
        int gap;
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= pair;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_pair(pair);
    endtask

    task automatic set_grav(logic [31:0] g);
        s_tvalid <= 0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (LAT + 10) @(posedge aclk);
        cfg_we    <= 1;
        cfg_wdata <= g;
        @(posedge aclk);
        cfg_we <= 0;
        board.grav = g;
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            1: return $urandom_range(0, 255) << 16;
            2: return -($urandom_range(0, 255) << 16);
            3: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [191:0] rnd_pair();
        logic [31:0] w[6];
        foreach (w[i]) w[i] = rnd_word();
        // near pairs give useful non-saturated results
        if ($urandom_range(0, 2) != 0) begin
            w[2] = w[0] + $urandom_range(0, 32'h40000) - 32'h20000;
            w[3] = w[1] + $urandom_range(0, 32'h40000) - 32'h20000;
            w[4] = $urandom_range(0, 32'h10_0000);
            w[5] = $urandom_range(0, 32'h10_0000);
        end
        if ($urandom_range(0, 30) == 0) begin
            w[2] = w[0];
            w[3] = w[1];
        end
        if ($urandom_range(0, 30) == 0) begin
            w[4] = 0;
            w[5] = 0;
        end
        return {w[5], w[4], w[3], w[2], w[1], w[0]};
    endfunction

    initial begin
        logic [31:0] gs[5];
        gs = '{32'h0001_0000, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'h0000_0400};
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed
        send_pair({32'h0001_0000, 32'h0001_0000, 32'd0, 32'h0001_0000, 32'd0, 32'd0});
        send_pair({32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                   32'h0003_0000, 32'h0004_0000});                     // zero distance
        send_pair({32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0});  // zero mass
        send_pair({32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'h0001_0000});
        send_pair({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0000});
        send_pair({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_pair({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0, 32'd0}); // saturates
        send_pair({32'd1, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0});
        send_pair({32'h0000_0100, 32'h0001_0000, 32'h0000_0100, 32'h0100_0000,
                   32'h0000_0100, 32'h0000_0000});
        send_pair({32'h0000_8000, 32'h0000_8000, 32'hFFFF_0000, 32'h0001_0000,
                   32'h0002_0000, 32'hFFFE_0000});
        foreach (gs[p]) begin
            set_grav(gs[p]);
            send_pair({32'h0002_0000, 32'h0001_0000, 32'h0000_0000, 32'h0003_0000,
                       32'h0001_0000, 32'h0000_0000});
            if (p == 4) calm = 1;
            for (int i = 0; i < 300; i++) begin
                if (p == 4 && i == 150) calm = 1;
                else if (p == 4 && i < 150) calm = 0;
                send_pair(rnd_pair());
            end
        end
        s_tvalid <= 0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (LAT + 10) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
